### src/bbi_pkg.sv
// ----------------------------------------------------------------------------
// bbi_pkg
// Shared types and fixed-point constants of the bicubic B-spline interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bbi_pkg;

    // field widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_BITS  = 4;
    localparam int ROW_BITS    = 2;

    // row codes
    localparam logic [ROW_BITS-1:0] ROW_TOP    = 2'd0;
    localparam logic [ROW_BITS-1:0] ROW_UPPER  = 2'd1;
    localparam logic [ROW_BITS-1:0] ROW_LOWER  = 2'd2;
    localparam logic [ROW_BITS-1:0] ROW_BOTTOM = 2'd3;

    // row queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // offset arithmetic: an offset and its complement range over 0..2^FRAC_BITS
    localparam int UNIT_BITS = FRAC_BITS + 1;
    localparam int SQ_BITS   = 2 * UNIT_BITS;
    localparam logic [UNIT_BITS-1:0] UNIT_ONE   = UNIT_BITS'(1) << FRAC_BITS;
    localparam logic [SQ_BITS-1:0]   ROUND_HALF = SQ_BITS'(1) << (FRAC_BITS - 1);

    // weights are scaled by 6 * 2^FRAC_BITS, signed
    localparam int W_BITS = FRAC_BITS + 4;
    localparam logic signed [W_BITS-1:0] W_ONE  = W_BITS'(1) <<< FRAC_BITS;
    localparam logic signed [W_BITS-1:0] W_FOUR = W_BITS'(4) <<< FRAC_BITS;
    localparam logic signed [W_BITS-1:0] W_SIX  = W_BITS'(6) <<< FRAC_BITS;

    // row reduction: divide by 6 * 2^(FRAC_BITS-GUARD_BITS) = 3 * 2^ROW_SHIFT
    localparam int PROD_BITS   = SAMPLE_BITS + W_BITS;
    localparam int ROWSUM_BITS = PROD_BITS + 2;
    localparam int ROW_SHIFT   = FRAC_BITS - GUARD_BITS + 1;
    localparam logic [ROWSUM_BITS:0] ROW_HALF = (ROWSUM_BITS + 1)'(3) << (ROW_SHIFT - 1);

    // shared divide-by-three unit (reciprocal multiply plus one correction)
    localparam int DIV_IN_BITS   = ROWSUM_BITS + 1 - ROW_SHIFT;
    localparam int DIV_SHIFT     = DIV_IN_BITS + 2;
    localparam int DIV_PROD_BITS = DIV_IN_BITS + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_MULT = DIV_SHIFT'((64'd1 << DIV_SHIFT) / 3);

    // accumulation and final scaling: divide by 6 * 2^(FRAC_BITS+GUARD_BITS)
    localparam int RN_BITS    = SAMPLE_BITS + GUARD_BITS + 1;
    localparam int TERM_BITS  = RN_BITS + W_BITS;
    localparam int ACC_BITS   = 64;
    localparam int OUT_SHIFT  = FRAC_BITS + GUARD_BITS + 1;
    localparam int OUT_X_BITS = ACC_BITS + 1 - OUT_SHIFT;
    localparam logic [ACC_BITS:0]     OUT_HALF = (ACC_BITS + 1)'(3) << (OUT_SHIFT - 1);
    localparam logic [OUT_X_BITS-1:0] SAT_LIM  = OUT_X_BITS'(3) << (SAMPLE_BITS - 1);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // one queued row
    typedef struct packed {
        logic [ROW_BITS-1:0]           row;
        logic                          start;
        logic                          finish;
        logic [FRAC_BITS-1:0]          frac_x;
        logic [FRAC_BITS-1:0]          frac_y;
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
    } t_entry;

    // four spline weights of one offset
    typedef struct packed {
        logic signed [W_BITS-1:0] w0;
        logic signed [W_BITS-1:0] w1;
        logic signed [W_BITS-1:0] w2;
        logic signed [W_BITS-1:0] w3;
    } t_weights;

    // weights of a zero offset
    localparam t_weights WEIGHTS_AT_ZERO = '{
        w0: W_ONE,
        w1: W_FOUR,
        w2: W_ONE,
        w3: W_BITS'(0)
    };

    // back-end sequencer
    typedef enum logic [3:0] {
        B_IDLE,
        B_W1,
        B_W2,
        B_W3,
        B_MUL,
        B_SUM,
        B_REC,
        B_FIX,
        B_WMUL,
        B_ACC,
        B_OSCALE,
        B_OREC,
        B_OFIX
    } t_back_state;

endpackage

`default_nettype wire

### src/bbi_front.sv
// ----------------------------------------------------------------------------
// bbi_front
// Accepts row transactions, tags start and finish rows and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module bbi_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [bbi_pkg::ROW_BITS-1:0]           i_row_index,
    input  logic [bbi_pkg::FRAC_BITS-1:0]          i_frac_x,
    input  logic [bbi_pkg::FRAC_BITS-1:0]          i_frac_y,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_3,
    output bbi_pkg::t_entry                        o_head,
    output logic                                   o_head_valid,
    input  logic                                   i_pop
);

    bbi_pkg::t_entry                  r_queue [bbi_pkg::QUEUE_DEPTH];
    logic [bbi_pkg::QPTR_BITS-1:0]    r_wr_ptr;
    logic [bbi_pkg::QPTR_BITS-1:0]    r_rd_ptr;
    logic [bbi_pkg::QCNT_BITS-1:0]    r_count;
    logic [bbi_pkg::QPTR_BITS-1:0]    n_wr_ptr;
    logic [bbi_pkg::QPTR_BITS-1:0]    n_rd_ptr;
    logic [bbi_pkg::QCNT_BITS-1:0]    n_count;
    logic                             w_push;
    bbi_pkg::t_entry                  w_entry;

    // classify the incoming row
    always_comb begin
        w_entry.row      = i_row_index;
        w_entry.start    = (i_row_index == bbi_pkg::ROW_TOP);
        w_entry.finish   = (i_row_index == bbi_pkg::ROW_BOTTOM);
        w_entry.frac_x   = i_frac_x;
        w_entry.frac_y   = i_frac_y;
        w_entry.sample_0 = i_sample_0;
        w_entry.sample_1 = i_sample_1;
        w_entry.sample_2 = i_sample_2;
        w_entry.sample_3 = i_sample_3;
    end

    // queue status
    assign o_stall      = (r_count == bbi_pkg::QCNT_BITS'(bbi_pkg::QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign o_head       = r_queue[r_rd_ptr];
    assign o_head_valid = (r_count != '0);

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == bbi_pkg::QPTR_BITS'(bbi_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == bbi_pkg::QPTR_BITS'(bbi_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_entry;
        end
    end

endmodule

`default_nettype wire

### src/bbi_weight.sv
// ----------------------------------------------------------------------------
// bbi_weight
// Three-step unit that turns one fractional offset into the four cubic
// B-spline weights and holds them until the next load.
// ----------------------------------------------------------------------------
`default_nettype none

module bbi_weight (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bbi_pkg::FRAC_BITS-1:0] i_frac,
    input  logic                          i_load,
    output bbi_pkg::t_weights             o_weights
);

    logic [bbi_pkg::UNIT_BITS-1:0] w_u;
    logic [bbi_pkg::UNIT_BITS-1:0] w_v;
    logic [bbi_pkg::SQ_BITS-1:0]   w_uu;
    logic [bbi_pkg::SQ_BITS-1:0]   w_vv;
    logic [bbi_pkg::UNIT_BITS-1:0] r_u;
    logic [bbi_pkg::UNIT_BITS-1:0] r_v;
    logic [bbi_pkg::UNIT_BITS-1:0] r_sq_u;
    logic [bbi_pkg::UNIT_BITS-1:0] r_sq_v;
    logic [bbi_pkg::SQ_BITS-1:0]   w_uuu;
    logic [bbi_pkg::SQ_BITS-1:0]   w_vvv;
    logic [bbi_pkg::UNIT_BITS-1:0] r_cu_u;
    logic [bbi_pkg::UNIT_BITS-1:0] r_cu_v;
    logic [bbi_pkg::UNIT_BITS-1:0] r_sq_u2;
    logic signed [bbi_pkg::W_BITS-1:0] w_cu_u;
    logic signed [bbi_pkg::W_BITS-1:0] w_cu_v;
    logic signed [bbi_pkg::W_BITS-1:0] w_sq_u;
    bbi_pkg::t_weights             n_weights;
    bbi_pkg::t_weights             r_weights;

    // step 1: rounded squares of the offset and its complement
    assign w_u  = {1'b0, i_frac};
    assign w_v  = bbi_pkg::UNIT_ONE - w_u;
    assign w_uu = bbi_pkg::SQ_BITS'(w_u) * bbi_pkg::SQ_BITS'(w_u) + bbi_pkg::ROUND_HALF;
    assign w_vv = bbi_pkg::SQ_BITS'(w_v) * bbi_pkg::SQ_BITS'(w_v) + bbi_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        r_u    <= w_u;
        r_v    <= w_v;
        r_sq_u <= w_uu[bbi_pkg::FRAC_BITS +: bbi_pkg::UNIT_BITS];
        r_sq_v <= w_vv[bbi_pkg::FRAC_BITS +: bbi_pkg::UNIT_BITS];
    end

    // step 2: rounded cubes
    assign w_uuu = bbi_pkg::SQ_BITS'(r_sq_u) * bbi_pkg::SQ_BITS'(r_u) + bbi_pkg::ROUND_HALF;
    assign w_vvv = bbi_pkg::SQ_BITS'(r_sq_v) * bbi_pkg::SQ_BITS'(r_v) + bbi_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        r_cu_u  <= w_uuu[bbi_pkg::FRAC_BITS +: bbi_pkg::UNIT_BITS];
        r_cu_v  <= w_vvv[bbi_pkg::FRAC_BITS +: bbi_pkg::UNIT_BITS];
        r_sq_u2 <= r_sq_u;
    end

    // step 3: combine into the four weights, sum fixed at six units
    assign w_cu_u = bbi_pkg::W_BITS'(r_cu_u);
    assign w_cu_v = bbi_pkg::W_BITS'(r_cu_v);
    assign w_sq_u = bbi_pkg::W_BITS'(r_sq_u2);

    always_comb begin
        n_weights.w0 = w_cu_v;
        n_weights.w3 = w_cu_u;
        n_weights.w1 = (w_cu_u <<< 1) + w_cu_u - ((w_sq_u <<< 2) + (w_sq_u <<< 1))
                       + bbi_pkg::W_FOUR;
        n_weights.w2 = bbi_pkg::W_SIX - n_weights.w0 - n_weights.w1 - n_weights.w3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= bbi_pkg::WEIGHTS_AT_ZERO;
        end else if (i_load) begin
            r_weights <= n_weights;
        end
    end

    assign o_weights = r_weights;

endmodule

`default_nettype wire

### src/bbi_back.sv
// ----------------------------------------------------------------------------
// bbi_back
// Sequencer that carries out one queued row at a time: weights on a start
// row, horizontal filter, row reduction, vertical weighting, accumulation,
// and on a finish row the final scaling into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbi_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bbi_pkg::t_entry                        i_head,
    input  logic                                   i_head_valid,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [bbi_pkg::SAMPLE_BITS-1:0] o_interpolated
);

    bbi_pkg::t_back_state r_state;
    bbi_pkg::t_back_state n_state;

    bbi_pkg::t_entry   r_cur;
    bbi_pkg::t_weights w_wx;
    bbi_pkg::t_weights w_wy;
    logic              w_wload;
    logic              w_out_load;
    logic              r_out_valid;
    logic              n_out_valid;
    logic signed [bbi_pkg::SAMPLE_BITS-1:0] r_out_data;

    logic signed [bbi_pkg::PROD_BITS-1:0]   r_prod [4];
    logic signed [bbi_pkg::ROWSUM_BITS-1:0] w_row_sum;
    logic [bbi_pkg::ROWSUM_BITS-1:0]        w_row_mag;
    logic [bbi_pkg::ROWSUM_BITS:0]          w_row_rnd;

    logic [bbi_pkg::DIV_IN_BITS-1:0]   r_div_in;
    logic [bbi_pkg::DIV_PROD_BITS-1:0] r_div_prod;
    logic                              r_neg;
    logic                              r_sat;
    logic [bbi_pkg::DIV_IN_BITS-2:0]   w_q0;
    logic [bbi_pkg::DIV_IN_BITS:0]     w_three_q0;
    logic [bbi_pkg::DIV_IN_BITS:0]     w_rem;
    logic [bbi_pkg::DIV_IN_BITS-1:0]   w_q;
    logic signed [bbi_pkg::RN_BITS-1:0]     w_rn_mag;
    logic signed [bbi_pkg::SAMPLE_BITS-1:0] w_out_mag;

    logic signed [bbi_pkg::RN_BITS-1:0]   r_rn;
    logic signed [bbi_pkg::W_BITS-1:0]    w_wy_sel;
    logic signed [bbi_pkg::TERM_BITS-1:0] r_term;
    logic signed [bbi_pkg::ACC_BITS-1:0]  r_acc;
    logic [bbi_pkg::ACC_BITS-1:0]         w_acc_mag;
    logic [bbi_pkg::ACC_BITS:0]           w_acc_rnd;
    logic [bbi_pkg::OUT_X_BITS-1:0]       w_out_x;

    // weight units for both axes
    bbi_weight u_weight_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frac    (r_cur.frac_x),
        .i_load    (w_wload),
        .o_weights (w_wx)
    );

    bbi_weight u_weight_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frac    (r_cur.frac_y),
        .i_load    (w_wload),
        .o_weights (w_wy)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbi_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_wload    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            bbi_pkg::B_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_head.start ? bbi_pkg::B_W1 : bbi_pkg::B_MUL;
                end
            end
            bbi_pkg::B_W1: n_state = bbi_pkg::B_W2;
            bbi_pkg::B_W2: n_state = bbi_pkg::B_W3;
            bbi_pkg::B_W3: begin
                w_wload = 1'b1;
                n_state = bbi_pkg::B_MUL;
            end
            bbi_pkg::B_MUL:  n_state = bbi_pkg::B_SUM;
            bbi_pkg::B_SUM:  n_state = bbi_pkg::B_REC;
            bbi_pkg::B_REC:  n_state = bbi_pkg::B_FIX;
            bbi_pkg::B_FIX:  n_state = bbi_pkg::B_WMUL;
            bbi_pkg::B_WMUL: n_state = bbi_pkg::B_ACC;
            bbi_pkg::B_ACC: begin
                n_state = r_cur.finish ? bbi_pkg::B_OSCALE : bbi_pkg::B_IDLE;
            end
            bbi_pkg::B_OSCALE: n_state = bbi_pkg::B_OREC;
            bbi_pkg::B_OREC:   n_state = bbi_pkg::B_OFIX;
            bbi_pkg::B_OFIX: begin
                if (!r_out_valid || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = bbi_pkg::B_IDLE;
                end
            end
            default: n_state = bbi_pkg::B_IDLE;
        endcase
    end

    // output register
    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign w_out_mag = w_q[bbi_pkg::SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_sat) begin
                r_out_data <= r_neg ? bbi_pkg::SAMPLE_MIN : bbi_pkg::SAMPLE_MAX;
            end else begin
                r_out_data <= r_neg ? -w_out_mag : w_out_mag;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_interpolated = r_out_data;

    // current row
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    // horizontal filter products
    always_ff @(posedge i_clk) begin
        if (r_state == bbi_pkg::B_MUL) begin
            r_prod[0] <= r_cur.sample_0 * w_wx.w0;
            r_prod[1] <= r_cur.sample_1 * w_wx.w1;
            r_prod[2] <= r_cur.sample_2 * w_wx.w2;
            r_prod[3] <= r_cur.sample_3 * w_wx.w3;
        end
    end

    // row sum, magnitude with rounding half and coarse shift
    assign w_row_sum = bbi_pkg::ROWSUM_BITS'(r_prod[0]) + bbi_pkg::ROWSUM_BITS'(r_prod[1])
                     + bbi_pkg::ROWSUM_BITS'(r_prod[2]) + bbi_pkg::ROWSUM_BITS'(r_prod[3]);
    assign w_row_mag = w_row_sum[bbi_pkg::ROWSUM_BITS-1] ? -w_row_sum : w_row_sum;
    assign w_row_rnd = {1'b0, w_row_mag} + bbi_pkg::ROW_HALF;

    // accumulator magnitude with rounding half and coarse shift
    assign w_acc_mag = r_acc[bbi_pkg::ACC_BITS-1] ? -r_acc : r_acc;
    assign w_acc_rnd = {1'b0, w_acc_mag} + bbi_pkg::OUT_HALF;
    assign w_out_x   = w_acc_rnd[bbi_pkg::ACC_BITS:bbi_pkg::OUT_SHIFT];

    // shared divide-by-three operand
    always_ff @(posedge i_clk) begin
        if (r_state == bbi_pkg::B_SUM) begin
            r_div_in <= w_row_rnd[bbi_pkg::ROWSUM_BITS:bbi_pkg::ROW_SHIFT];
            r_neg    <= w_row_sum[bbi_pkg::ROWSUM_BITS-1];
        end else if (r_state == bbi_pkg::B_OSCALE) begin
            r_div_in <= bbi_pkg::DIV_IN_BITS'(w_out_x[bbi_pkg::SAMPLE_BITS:0]);
            r_neg    <= r_acc[bbi_pkg::ACC_BITS-1];
            r_sat    <= (w_out_x >= bbi_pkg::SAT_LIM);
        end
    end

    // reciprocal multiply, then one correction step
    always_ff @(posedge i_clk) begin
        r_div_prod <= bbi_pkg::DIV_PROD_BITS'(r_div_in) *
                      bbi_pkg::DIV_PROD_BITS'(bbi_pkg::DIV_MULT);
    end

    // the estimate stays below a third of the operand, so the top product bit is zero
    assign w_q0       = r_div_prod[bbi_pkg::DIV_PROD_BITS-2:bbi_pkg::DIV_SHIFT];
    assign w_three_q0 = {w_q0, 1'b0} + (bbi_pkg::DIV_IN_BITS + 1)'(w_q0);
    assign w_rem      = {1'b0, r_div_in} - w_three_q0;
    assign w_q        = bbi_pkg::DIV_IN_BITS'(w_q0)
                      + bbi_pkg::DIV_IN_BITS'(w_rem >= (bbi_pkg::DIV_IN_BITS + 1)'(3));
    assign w_rn_mag   = w_q[bbi_pkg::RN_BITS-1:0];

    // reduced row value, signed
    always_ff @(posedge i_clk) begin
        if (r_state == bbi_pkg::B_FIX) begin
            r_rn <= r_neg ? -w_rn_mag : w_rn_mag;
        end
    end

    // vertical weight of this row
    always_comb begin
        case (r_cur.row)
            bbi_pkg::ROW_TOP:    w_wy_sel = w_wy.w0;
            bbi_pkg::ROW_UPPER:  w_wy_sel = w_wy.w1;
            bbi_pkg::ROW_LOWER:  w_wy_sel = w_wy.w2;
            bbi_pkg::ROW_BOTTOM: w_wy_sel = w_wy.w3;
            default:             w_wy_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbi_pkg::B_WMUL) begin
            r_term <= r_rn * w_wy_sel;
        end
    end

    // accumulator, restarted by a start row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == bbi_pkg::B_ACC) begin
            r_acc <= (r_cur.start ? '0 : r_acc) + bbi_pkg::ACC_BITS'(r_term);
        end
    end

endmodule

`default_nettype wire

### src/bicubic_bspline_interpolation.sv
// ----------------------------------------------------------------------------
// bicubic_bspline_interpolation
// Cubic B-spline interpolation over a 4x4 sample neighbourhood, fed by rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one row of four signed samples per
//   transaction, with its row index. Row 0 latches frac_x and frac_y and starts
//   a new sum; rows 1 and 2 add to it; row 3 adds and produces one result on
//   the output channel (o_valid / i_stall). Rows 0..2 produce no result.
//   A two-entry queue sits between the input side and the datapath sequencer,
//   so rows are taken while the sequencer works or a result waits.
//   The sequencer works on one row at a time and takes the next queued row
//   only when done with the current one; rows 0 and 3 take extra steps
//   (weights on row 0, final scaling on row 3). The output register holds a
//   result until taken; while i_stall is high the sequencer waits on the next
//   finish row, the queue fills and o_stall rises.
//   Reset (synchronous, active low) empties the queue, drops o_valid, clears the
//   sum and returns the weights to those of zero offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module bicubic_bspline_interpolation (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [bbi_pkg::ROW_BITS-1:0]           i_row_index,
    input  logic [bbi_pkg::FRAC_BITS-1:0]          i_frac_x,
    input  logic [bbi_pkg::FRAC_BITS-1:0]          i_frac_y,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [bbi_pkg::SAMPLE_BITS-1:0] i_sample_3,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [bbi_pkg::SAMPLE_BITS-1:0] o_interpolated
);

    bbi_pkg::t_entry w_head;
    logic            w_head_valid;
    logic            w_pop;

    // front: accept, classify, queue
    bbi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_row_index  (i_row_index),
        .i_frac_x     (i_frac_x),
        .i_frac_y     (i_frac_y),
        .i_sample_0   (i_sample_0),
        .i_sample_1   (i_sample_1),
        .i_sample_2   (i_sample_2),
        .i_sample_3   (i_sample_3),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    // back: weights, filter, accumulate, output
    bbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_head_valid   (w_head_valid),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_interpolated (o_interpolated)
    );

    // queue is never read while empty
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("row taken from an empty queue");

    // the sequencer takes one row at a time
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("rows taken on consecutive cycles");

    // a full queue always offers a row
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_head_valid)
        else $error("input stalled with no row queued");

endmodule

`default_nettype wire
